>>> src/mstp_pkg.sv
// mstp_pkg: shared types, result codes and crc step functions for the ms/tp receiver
// no dependencies; imported by mstp_parser, mstp_frame_receiver, mstp_frame_checker and mstp_frame_receiver_tb
package mstp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PRE2   = 3'd1,
    PH_HEADER = 3'd2,
    PH_HCRC   = 3'd3,
    PH_DATA   = 3'd4,
    PH_DCRC1  = 3'd5,
    PH_DCRC2  = 3'd6
  } phase_t;

  localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
  localparam logic [2:0] KIND_NO_DATA   = 3'd1;
  localparam logic [2:0] KIND_FWD_DATA  = 3'd2;
  localparam logic [2:0] KIND_OTHER     = 3'd3;
  localparam logic [2:0] KIND_HDR_ERR   = 3'd4;
  localparam logic [2:0] KIND_DATA_ERR  = 3'd5;

  localparam logic [7:0]  PREAMBLE_1    = 8'h55;
  localparam logic [7:0]  PREAMBLE_2    = 8'hFF;
  localparam logic [7:0]  CRC8_INIT     = 8'hFF;
  localparam logic [7:0]  CRC8_RESIDUE  = 8'h55;
  localparam logic [15:0] CRC16_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC16_RESIDUE = 16'hF0B8;
  localparam logic [7:0]  TYPE_DATA_ER  = 8'h05;
  localparam logic [7:0]  TYPE_DATA_NER = 8'h06;
  localparam logic [15:0] MAX_LEN_RESET = 16'd501;

  localparam int OUT_DATA_W = 136;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_kind;
    logic [7:0]  dest_address;
    logic [7:0]  source_address;
    logic [15:0] frame_length;
    logic [31:0] good_total;
    logic [31:0] crc_total;
    logic        bus_seen;
  } mstp_result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] data, input logic [7:0] crc);
    logic [15:0] t;
    t = {8'h00, crc ^ data};
    t = t ^ (t << 1) ^ (t << 2) ^ (t << 3) ^ (t << 4) ^ (t << 5) ^ (t << 6) ^ (t << 7);
    return (t[7:0] & 8'hFE) ^ {7'd0, t[8]};
  endfunction

  function automatic logic [15:0] crc16_step(input logic [7:0] data, input logic [15:0] crc);
    logic [15:0] lo;
    logic [15:0] lo_n;
    lo   = {8'h00, crc[7:0] ^ data};
    lo_n = lo & 16'h000F;
    return (crc >> 8) ^ (lo << 8) ^ (lo << 3) ^ (lo << 12) ^ (lo >> 4) ^ lo_n ^ (lo_n << 7);
  endfunction

endpackage

>>> src/mstp_parser.sv
// mstp_parser: ms/tp receive state machine, header/data crc and frame counters
// depends on mstp_pkg; produces at most one result per accepted byte
module mstp_parser import mstp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         byte_valid,
  input  logic [7:0]   rx_byte,
  input  logic [15:0]  max_len,
  output logic         res_valid,
  output mstp_result_t res
);

  phase_t phase_r, phase_nxt;
  logic [2:0]             hcnt_r, hcnt_nxt;
  logic [LENGTH_BITS-1:0] pcnt_r, pcnt_nxt;
  logic [7:0]             crc8_r, crc8_nxt;
  logic [15:0]            crc16_r, crc16_nxt;
  logic [31:0]            good_r, good_nxt;
  logic [31:0]            errs_r, errs_nxt;
  logic                   bus_r, bus_nxt;
  logic [7:0]             hdr_r [5];

  logic [7:0]             crc8_calc;
  logic [15:0]            crc16_calc;
  logic [15:0]            len;
  logic [LENGTH_BITS-1:0] pcnt_inc;
  logic                   is_data_type;
  logic                   len_too_big;
  logic                   hcrc_ok;

  assign crc8_calc    = crc8_step(rx_byte, crc8_r);
  assign crc16_calc   = crc16_step(rx_byte, crc16_r);
  assign len          = {hdr_r[3], hdr_r[4]};
  assign pcnt_inc     = pcnt_r + 1'b1;
  assign is_data_type = (hdr_r[0] == TYPE_DATA_ER) || (hdr_r[0] == TYPE_DATA_NER);
  assign len_too_big  = (len > max_len) || ((len >> LENGTH_BITS) != 16'd0);
  assign hcrc_ok      = (crc8_calc == CRC8_RESIDUE);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (byte_valid) begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_byte == PREAMBLE_1) phase_nxt = PH_PRE2;
        end
        PH_PRE2: begin
          if (rx_byte == PREAMBLE_2) phase_nxt = PH_HEADER;
          else if (rx_byte != PREAMBLE_1) phase_nxt = PH_IDLE;
        end
        PH_HEADER: begin
          if (hcnt_r == 3'd4) phase_nxt = PH_HCRC;
        end
        PH_HCRC: begin
          if (hcrc_ok && (len != 16'd0) && !len_too_big) phase_nxt = PH_DATA;
          else phase_nxt = PH_IDLE;
        end
        PH_DATA: begin
          if (16'(pcnt_inc) >= len) phase_nxt = PH_DCRC1;
        end
        PH_DCRC1: phase_nxt = PH_DCRC2;
        PH_DCRC2: phase_nxt = PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    hcnt_nxt  = hcnt_r;
    pcnt_nxt  = pcnt_r;
    crc8_nxt  = crc8_r;
    crc16_nxt = crc16_r;
    good_nxt  = good_r;
    errs_nxt  = errs_r;
    bus_nxt   = bus_r;
    res_valid = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.payload_byte  = 8'd0;
    res.payload_index = 16'd0;
    if (byte_valid) begin
      case (phase_r)
        PH_PRE2: begin
          if (rx_byte == PREAMBLE_2) begin
            hcnt_nxt = 3'd0;
            crc8_nxt = CRC8_INIT;
          end
        end
        PH_HEADER: begin
          crc8_nxt = crc8_calc;
          hcnt_nxt = hcnt_r + 3'd1;
        end
        PH_HCRC: begin
          crc8_nxt = crc8_calc;
          if (!hcrc_ok) begin
            errs_nxt  = errs_r + 32'd1;
            res_valid = 1'b1;
            res.kind  = KIND_HDR_ERR;
          end else if (len == 16'd0) begin
            good_nxt  = good_r + 32'd1;
            bus_nxt   = 1'b1;
            res_valid = 1'b1;
            res.kind  = KIND_NO_DATA;
          end else if (!len_too_big) begin
            pcnt_nxt  = '0;
            crc16_nxt = CRC16_INIT;
          end
        end
        PH_DATA: begin
          crc16_nxt = crc16_calc;
          pcnt_nxt  = pcnt_inc;
          if (is_data_type) begin
            res_valid         = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = rx_byte;
            res.payload_index = 16'(pcnt_r);
          end
        end
        PH_DCRC1: crc16_nxt = crc16_calc;
        PH_DCRC2: begin
          crc16_nxt = crc16_calc;
          res_valid = 1'b1;
          if (crc16_calc != CRC16_RESIDUE) begin
            errs_nxt = errs_r + 32'd1;
            res.kind = KIND_DATA_ERR;
          end else begin
            good_nxt = good_r + 32'd1;
            bus_nxt  = 1'b1;
            res.kind = is_data_type ? KIND_FWD_DATA : KIND_OTHER;
          end
        end
        default: ;
      endcase
    end
    res.frame_kind     = hdr_r[0];
    res.dest_address   = hdr_r[1];
    res.source_address = hdr_r[2];
    res.frame_length   = len;
    res.good_total     = good_nxt;
    res.crc_total      = errs_nxt;
    res.bus_seen       = bus_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hcnt_r  <= 3'd0;
      pcnt_r  <= '0;
      crc8_r  <= CRC8_INIT;
      crc16_r <= CRC16_INIT;
      good_r  <= 32'd0;
      errs_r  <= 32'd0;
      bus_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      pcnt_r  <= pcnt_nxt;
      crc8_r  <= crc8_nxt;
      crc16_r <= crc16_nxt;
      good_r  <= good_nxt;
      errs_r  <= errs_nxt;
      bus_r   <= bus_nxt;
    end
  end

  // header bytes hold no reset value
  always_ff @(posedge clk) begin
    if (byte_valid && phase_r == PH_HEADER) hdr_r[hcnt_r] <= rx_byte;
  end

  a_payload_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_PAYLOAD |-> phase_r == PH_DATA)
    else $error("payload result outside data phase");

  a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> hcnt_r <= 3'd4)
    else $error("header count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (good_r - $past(good_r)) + (errs_r - $past(errs_r)) <= 32'd1)
    else $error("frame counters moved by more than one frame");

  a_bus_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    bus_r |=> bus_r)
    else $error("bus seen flag dropped");

endmodule

>>> src/mstp_frame_receiver.sv
// mstp_frame_receiver: top level of the ms/tp frame receiver with config register
// and two-entry output buffer; depends on mstp_pkg and mstp_parser
//
// Usage
//   in_*  : one received serial byte per transfer, in_tdata[7:0] = rx_byte.
//   out_* : result transfers. out_tuser[2:0] = result kind: payload byte,
//           good frame without data, good type 5/6 frame, good other frame,
//           header crc error, data crc error. Payload bytes of type 5/6 frames
//           stream out as they arrive; the verdict transfer that follows
//           tells the consumer to commit or drop them.
//   cfg_* : writes the maximum payload length; longer frames are dropped
//           after their header without any result. Write only while idle.
// Timing
//   one byte per cycle while in_tready is high. Each result is registered in the
//   output register, or in the skid entry if that is held; parser state and crc
//   update in one pass per byte, and the two entries let input keep flowing while
//   a result waits. If the consumer stalls, in_tready falls once both entries fill.
// Reset
//   rst_n low returns the parser to preamble hunt, clears counters and the
//   bus seen flag, empties the output buffer and loads max length 501.
module mstp_frame_receiver import mstp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_kind,
  // [39:32] dest_address, [47:40] source_address, [63:48] frame_length,
  // [95:64] good_frame_total, [127:96] crc_error_total, [128] bus_seen
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser,  // [2:0] result_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data    // [15:0] max_payload_length
);

  logic [15:0]  max_len_r;
  logic         in_fire;
  logic         res_valid;
  mstp_result_t res;

  logic         out_v_r, out_v_nxt;
  logic         skid_v_r, skid_v_nxt;
  mstp_result_t out_r, skid_r;
  logic         pop;
  logic         push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= MAX_LEN_RESET;
    else if (cfg_valid) max_len_r <= cfg_data;
  end

  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;

  mstp_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_fire),
    .rx_byte    (in_tdata),
    .max_len    (max_len_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign pop  = out_v_r && out_tready;
  assign push = in_fire && res_valid;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (pop) skid_v_nxt = 1'b0;
    end else if (push) begin
      if (out_v_r && !pop) skid_v_nxt = 1'b1;
      else out_v_nxt = 1'b1;
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) out_r <= skid_r;
    end else if (push) begin
      if (out_v_r && !pop) skid_r <= res;
      else out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {7'd0, out_r.bus_seen, out_r.crc_total, out_r.good_total,
                       out_r.frame_length, out_r.source_address, out_r.dest_address,
                       out_r.frame_kind, out_r.payload_index, out_r.payload_byte};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held with output register empty");

  a_skid_refills: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_tready |=> out_v_r && !skid_v_r)
    else $error("skid entry not moved to output after transfer");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r && $stable(skid_r))
    else $error("skid entry changed while output stalled");

endmodule

>>> tb/mstp_frame_checker.sv
// mstp_frame_checker: watches the byte, result and config channels of the ms/tp receiver,
// predicts every result from the accepted bytes and compares them in order
// depends on mstp_pkg for the result layout, kinds, phases and crc constants
`timescale 1ns / 1ps

module mstp_frame_checker import mstp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_kind,
  // [39:32] dest_address, [47:40] source_address, [63:48] frame_length,
  // [95:64] good_frame_total, [127:96] crc_error_total, [128] bus_seen
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [2:0]            out_tuser,  // [2:0] result_kind
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [15:0]           cfg_data,   // [15:0] max_payload_length
  output int                    fail_count,
  output int                    pending
);

  localparam int LEN_CAP = (1 << LENGTH_BITS) - 1;

  phase_t       rx_phase;
  logic [7:0]   hdr_bytes [5];
  logic [2:0]   hdr_cnt;
  logic [15:0]  data_cnt;
  logic [7:0]   hdr_crc;
  logic [15:0]  data_crc;
  logic [31:0]  good_frames;
  logic [31:0]  crc_errors;
  logic         frame_seen;
  logic [15:0]  len_limit;

  mstp_result_t predicted_results [$];
  mstp_result_t got;
  mstp_result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // annex g header crc, one byte: xor the copies shifted by 0 to 7, then fold bit 8 into bit 0
  function automatic logic [7:0] hdr_crc_next(input logic [7:0] b, input logic [7:0] crc);
    logic [15:0] t;
    logic [15:0] acc;
    t   = {8'h00, crc ^ b};
    acc = '0;
    for (int k = 0; k < 8; k++) acc = acc ^ (t << k);
    return {acc[7:1], acc[8]};
  endfunction

  // annex g data crc, one byte, low byte of the register first
  function automatic logic [15:0] data_crc_next(input logic [7:0] b, input logic [15:0] crc);
    logic [7:0] lo;
    lo = crc[7:0] ^ b;
    return {8'h00, crc[15:8]} ^ {lo, 8'h00} ^ {5'd0, lo, 3'd0} ^ {lo[3:0], 12'd0}
         ^ {12'd0, lo[7:4]} ^ {12'd0, lo[3:0]} ^ {5'd0, lo[3:0], 7'd0};
  endfunction

  function automatic void push_result(input logic [2:0] kind, input logic [7:0] pbyte,
                                      input logic [15:0] pidx);
    mstp_result_t r;
    r.kind           = kind;
    r.payload_byte   = pbyte;
    r.payload_index  = pidx;
    r.frame_kind     = hdr_bytes[0];
    r.dest_address   = hdr_bytes[1];
    r.source_address = hdr_bytes[2];
    r.frame_length   = {hdr_bytes[3], hdr_bytes[4]};
    r.good_total     = good_frames;
    r.crc_total      = crc_errors;
    r.bus_seen       = frame_seen;
    predicted_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [15:0] hdr_len;
    logic [15:0] slot;
    hdr_len = {hdr_bytes[3], hdr_bytes[4]};
    case (rx_phase)
      PH_IDLE: begin
        if (b == PREAMBLE_1) rx_phase = PH_PRE2;
      end
      PH_PRE2: begin
        if (b == PREAMBLE_2) begin
          rx_phase = PH_HEADER;
          hdr_cnt  = '0;
          hdr_crc  = CRC8_INIT;
        end else if (b != PREAMBLE_1) begin
          rx_phase = PH_IDLE;
        end
      end
      PH_HEADER: begin
        hdr_bytes[int'(hdr_cnt) % 5] = b;
        hdr_crc = hdr_crc_next(b, hdr_crc);
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt >= 3'd5) rx_phase = PH_HCRC;
      end
      PH_HCRC: begin
        hdr_crc  = hdr_crc_next(b, hdr_crc);
        rx_phase = PH_IDLE;
        if (hdr_crc != CRC8_RESIDUE) begin
          crc_errors = crc_errors + 1;
          push_result(KIND_HDR_ERR, 8'h00, 16'h0000);
        end else if (hdr_len == 16'd0) begin
          good_frames = good_frames + 1;
          frame_seen  = 1'b1;
          push_result(KIND_NO_DATA, 8'h00, 16'h0000);
        end else if (hdr_len <= len_limit && 32'(hdr_len) <= LEN_CAP) begin
          // oversized headers fall through silently and the hunt restarts
          data_cnt = '0;
          data_crc = CRC16_INIT;
          rx_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        slot     = data_cnt;
        data_crc = data_crc_next(b, data_crc);
        data_cnt = 16'((32'(data_cnt) + 1) & LEN_CAP);
        if (data_cnt >= hdr_len) rx_phase = PH_DCRC1;
        if (hdr_bytes[0] == TYPE_DATA_ER || hdr_bytes[0] == TYPE_DATA_NER)
          push_result(KIND_PAYLOAD, b, slot);
      end
      PH_DCRC1: begin
        data_crc = data_crc_next(b, data_crc);
        rx_phase = PH_DCRC2;
      end
      PH_DCRC2: begin
        data_crc = data_crc_next(b, data_crc);
        rx_phase = PH_IDLE;
        if (data_crc != CRC16_RESIDUE) begin
          crc_errors = crc_errors + 1;
          push_result(KIND_DATA_ERR, 8'h00, 16'h0000);
        end else begin
          good_frames = good_frames + 1;
          frame_seen  = 1'b1;
          if (hdr_bytes[0] == TYPE_DATA_ER || hdr_bytes[0] == TYPE_DATA_NER)
            push_result(KIND_FWD_DATA, 8'h00, 16'h0000);
          else
            push_result(KIND_OTHER, 8'h00, 16'h0000);
        end
      end
      default: rx_phase = PH_IDLE;
    endcase
  endfunction

  function automatic string describe(input mstp_result_t r);
    return $sformatf("kind %0d byte %h idx %0d type %h dst %h src %h len %0d good %0d err %0d seen %b",
                     r.kind, r.payload_byte, r.payload_index, r.frame_kind, r.dest_address,
                     r.source_address, r.frame_length, r.good_total, r.crc_total, r.bus_seen);
  endfunction

  function automatic void note_failure(input string what, input string exp_s, input string act_s);
    fail_count = fail_count + 1;
    if (fail_count <= 10)
      $display("%0t: %s\n  expected: %s\n  actual:   %s", $realtime, what, exp_s, act_s);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase    = PH_IDLE;
      for (int k = 0; k < 5; k++) hdr_bytes[k] = 8'h00;
      hdr_cnt     = '0;
      data_cnt    = '0;
      hdr_crc     = CRC8_INIT;
      data_crc    = CRC16_INIT;
      good_frames = '0;
      crc_errors  = '0;
      frame_seen  = 1'b0;
      len_limit   = MAX_LEN_RESET;
      predicted_results.delete();
    end else begin
      // results leave only after their byte has been registered, so compare before predicting
      if (out_tvalid && out_tready) begin
        got.kind           = out_tuser;
        got.payload_byte   = out_tdata[7:0];
        got.payload_index  = out_tdata[23:8];
        got.frame_kind     = out_tdata[31:24];
        got.dest_address   = out_tdata[39:32];
        got.source_address = out_tdata[47:40];
        got.frame_length   = out_tdata[63:48];
        got.good_total     = out_tdata[95:64];
        got.crc_total      = out_tdata[127:96];
        got.bus_seen       = out_tdata[128];
        if (predicted_results.size() == 0) begin
          note_failure("result transfer with nothing expected", "none", describe(got));
        end else begin
          want = predicted_results.pop_front();
          if (got !== want) note_failure("result mismatch", describe(want), describe(got));
        end
      end
      if (cfg_valid && cfg_ready) len_limit = cfg_data;
      if (in_tvalid && in_tready) parse_rx_byte(in_tdata);
    end
    pending = predicted_results.size();
  end

endmodule

>>> tb/mstp_frame_receiver_tb.sv
// mstp_frame_receiver_tb: drives serial bytes and max length writes into the ms/tp receiver,
// stalls the result side at random and gives the verdict from mstp_frame_checker
// depends on mstp_pkg, mstp_frame_receiver and mstp_frame_checker
`timescale 1ns / 1ps

module mstp_frame_receiver_tb;
  import mstp_pkg::*;

  localparam int LEN_BITS      = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int CHOKE_CYCLES  = 60;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [15:0]           cfg_data;

  logic        in_fire  = 1'b0;
  logic        cfg_fire = 1'b0;
  int          fail_count;
  int          pending;
  int          bytes_sent = 0;
  int          gap_pct    = 0;
  int          stall_pct  = 0;
  bit          choke_req  = 1'b0;
  logic [15:0] cur_max;

  mstp_frame_receiver #(.LENGTH_BITS(LEN_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  mstp_frame_checker #(.LENGTH_BITS(LEN_BITS)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // remember which transfers completed at the last rising edge
  always @(posedge clk) begin
    in_fire  <= in_tvalid && in_tready;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // result side: random hold-offs, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req) begin
        out_tready = 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
        choke_req = 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    @(negedge clk);
    while (!in_fire) @(negedge clk);
    bytes_sent++;
  endtask

  // preamble, header, header crc, then payload and data crc when the frame is accepted
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len, input int n55,
                            input bit bad_hdr, input bit bad_data);
    logic [7:0]  frame_hdr [5];
    logic [7:0]  hc;
    logic [15:0] dc;
    logic [7:0]  b;
    frame_hdr[0] = ftype;
    frame_hdr[1] = 8'($urandom);
    frame_hdr[2] = 8'($urandom);
    frame_hdr[3] = len[15:8];
    frame_hdr[4] = len[7:0];
    repeat (n55) send_byte(PREAMBLE_1);
    send_byte(PREAMBLE_2);
    hc = CRC8_INIT;
    for (int k = 0; k < 5; k++) begin
      send_byte(frame_hdr[k]);
      hc = crc8_step(frame_hdr[k], hc);
    end
    hc = ~hc;
    if (bad_hdr) hc ^= 8'($urandom_range(1, 255));
    send_byte(hc);
    if (bad_hdr || len == 16'd0 || len > cur_max) return;
    dc = CRC16_INIT;
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom);
      send_byte(b);
      dc = crc16_step(b, dc);
    end
    dc = ~dc;
    if (bad_data) dc ^= 16'($urandom_range(1, 65535));
    send_byte(dc[7:0]);
    send_byte(dc[15:8]);
  endtask

  // line noise with stray preamble starts, never a full 55 ff pair
  task automatic send_noise(input int n);
    logic [7:0] b;
    logic [7:0] prev;
    prev = 8'h00;
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom);
      if ($urandom_range(3) == 0) b = PREAMBLE_1;
      if (prev == PREAMBLE_1 && b == PREAMBLE_2) b = 8'h00;
      send_byte(b);
      prev = b;
    end
  endtask

  task automatic run_traffic(input int budget);
    int          stop_at;
    int          pick;
    int          span;
    bit          hdr_bad;
    logic [7:0]  ftype;
    logic [15:0] len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      ftype = ($urandom_range(99) < 40) ? TYPE_DATA_ER :
              ($urandom_range(99) < 40) ? TYPE_DATA_NER : 8'($urandom);
      if (pick < 6) begin
        send_noise($urandom_range(1, 6));
      end else if (pick < 9 && cur_max < 16'd1000) begin
        // header cut short: the next frame's bytes complete it
        send_byte(PREAMBLE_1);
        send_byte(PREAMBLE_2);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
      end else if (pick < 16 && cur_max < 16'hFFFF) begin
        span = 32'hFFFF - int'(cur_max);
        len  = 16'(int'(cur_max) + 1 + int'($urandom % span));
        send_frame(ftype, len, 1, 1'b0, 1'b0);
      end else begin
        pick = $urandom_range(99);
        len  = (pick < 15) ? 16'd0 :
               (pick < 95) ? 16'($urandom_range(1, 24)) : 16'($urandom_range(25, 80));
        if (len > cur_max) len = cur_max;
        hdr_bad = ($urandom_range(99) < 8);
        if (hdr_bad) len = 16'($urandom);
        send_frame(ftype, len, $urandom_range(1, 3), hdr_bad, $urandom_range(99) < 8);
      end
    end
  endtask

  // drop the byte channel and wait until every predicted result has been seen
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(negedge clk);
    while (!cfg_fire) @(negedge clk);
    cfg_valid = 1'b0;
    cur_max   = v;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    cfg_valid = 1'b0;
    cfg_data  = 16'h0000;
    cur_max   = MAX_LEN_RESET;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // stray bytes and a broken preamble, then one frame of each outcome
    send_byte(8'h00);
    send_byte(PREAMBLE_2);
    send_byte(PREAMBLE_1);
    send_byte(8'h00);
    send_frame(8'h00, 16'h0000, 1, 1'b1, 1'b0);
    send_frame(TYPE_DATA_ER, 16'd0, 2, 1'b0, 1'b0);
    send_frame(TYPE_DATA_NER, 16'd2, 1, 1'b0, 1'b0);
    send_frame(8'hFF, 16'd1, 1, 1'b0, 1'b0);
    send_frame(TYPE_DATA_ER, 16'd1, 3, 1'b0, 1'b1);
    send_frame(TYPE_DATA_ER, 16'd600, 1, 1'b0, 1'b0);

    // back-to-back payload against a long receiver hold-off fills the output buffer
    choke_req = 1'b1;
    send_frame(TYPE_DATA_ER, 16'd40, 1, 1'b0, 1'b0);
    gap_pct   = 30;
    stall_pct = 30;
    run_traffic(300);

    write_max_len(16'h0000);
    gap_pct   = 5;
    stall_pct = 50;
    run_traffic(100);

    // exactly at the limit, then one over
    write_max_len(MAX_LEN_RESET);
    gap_pct   = 10;
    stall_pct = 10;
    send_frame(TYPE_DATA_NER, MAX_LEN_RESET, 1, 1'b0, 1'b0);
    send_frame(TYPE_DATA_ER, MAX_LEN_RESET + 16'd1, 1, 1'b0, 1'b0);
    run_traffic(100);

    write_max_len(16'($urandom_range(1, 40)));
    gap_pct   = 20;
    stall_pct = 40;
    run_traffic(250);

    write_max_len(16'hFFFF);
    gap_pct   = 40;
    stall_pct = 15;
    run_traffic(250);

    write_max_len(16'($urandom_range(41, 600)));
    gap_pct   = 0;
    stall_pct = 0;
    run_traffic(200);

    drain();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
src/mstp_pkg.sv
src/mstp_parser.sv
src/mstp_frame_receiver.sv
tb/mstp_frame_checker.sv
tb/mstp_frame_receiver_tb.sv
